@@ src/tcb_pkg.sv @@
// shared constants, types and helper functions of the traffic counter bank
// no dependencies; used by tcb_alu, tcb_group_ram and the core top level
package tcb_pkg;

    // sizing of the counter bank
    localparam int CATEGORY_COUNT = 8;
    localparam int GROUP_COUNT    = 8;
    localparam int COUNTER_WIDTH  = 64;

    localparam int MATH_W   = 64;
    localparam int RAM_DEPTH = GROUP_COUNT * CATEGORY_COUNT;
    localparam int ADDR_W   = $clog2(RAM_DEPTH);
    localparam int CAT_W    = $clog2(CATEGORY_COUNT);
    localparam int MUL_STEPS = 31;

    // operation codes
    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_RTT   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // ip family codes
    localparam logic [1:0] FAM_IPV4 = 2'd1;
    localparam logic [1:0] FAM_IPV6 = 2'd2;

    // groups and categories with a fixed role
    localparam logic [2:0] GRP_TOTAL = 3'd0;
    localparam logic [2:0] GRP_ICMP4 = 3'd1;
    localparam logic [2:0] GRP_ARP   = 3'd5;
    localparam logic [2:0] GRP_IPV4  = 3'd6;
    localparam logic [2:0] GRP_IPV6  = 3'd7;
    localparam logic [2:0] CAT_RCVD  = 3'd1;

    // rtt figures
    localparam logic [31:0] RTT_NONE = 32'hFFFF_FFFF;
    localparam logic [31:0] RTT_SAT  = 32'h7FFF_FFFF;

    // counter memory port
    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic [COUNTER_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } ram_req_t;

    // shared adder request and result
    typedef struct packed {
        logic [MATH_W-1:0] a;
        logic [MATH_W-1:0] b;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic [MATH_W-1:0] sum;
        logic              carry;
    } alu_res_t;

    // group/category pair lies inside the bank
    function automatic logic cell_ok(input logic [2:0] grp, input logic [2:0] cat);
        return (32'(grp) < GROUP_COUNT) && (32'(cat) < CATEGORY_COUNT);
    endfunction

    function automatic logic cat_ok(input logic [2:0] cat);
        return 32'(cat) < CATEGORY_COUNT;
    endfunction

    // flat memory address of a group/category pair
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [2:0] grp,
                                                    input logic [2:0] cat);
        logic [8:0] flat;
        flat = 9'(grp) * 9'(CATEGORY_COUNT) + 9'(cat);
        return flat[ADDR_W-1:0];
    endfunction

    // byte counter index of a category
    function automatic logic [CAT_W-1:0] cat_index(input logic [2:0] cat);
        logic [3:0] wide;
        wide = 4'(cat);
        return wide[CAT_W-1:0];
    endfunction

endpackage

@@ src/tcb_alu.sv @@
// shared 64-bit add/subtract unit of the traffic counter bank
// depends on tcb_pkg for the request and result types
module tcb_alu (
    input  tcb_pkg::alu_req_t req,
    output tcb_pkg::alu_res_t res
);

    logic [tcb_pkg::MATH_W-1:0] operand_b;

    // subtract as add of the complement, carry high means no borrow
    assign operand_b = req.sub ? ~req.b : req.b;
    assign {res.carry, res.sum} = {1'b0, req.a} + {1'b0, operand_b}
                                  + (tcb_pkg::MATH_W + 1)'(req.sub);

endmodule

@@ src/tcb_group_ram.sv @@
// packet counter memory, one write and one registered read port
// valid bits cleared by reset make unwritten entries read as zero; uses tcb_pkg
module tcb_group_ram (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tcb_pkg::ram_req_t                  req,
    output logic [tcb_pkg::COUNTER_WIDTH-1:0]  rd_data
);

    logic [tcb_pkg::COUNTER_WIDTH-1:0] mem_reg [tcb_pkg::RAM_DEPTH];
    logic [tcb_pkg::COUNTER_WIDTH-1:0] rd_data_reg;
    logic [tcb_pkg::RAM_DEPTH-1:0]     valid_reg;
    logic                              rd_valid_reg;

    // storage array and read data
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem_reg[req.raddr];
    end

    // per-entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.raddr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ src/traffic_counter_bank_with_rtt_stats_core.sv @@
// top level of the traffic counter bank with rtt statistics
// depends on tcb_pkg, tcb_alu and tcb_group_ram
//
// Usage:
//   s_axis carries one command per beat; s_axis_tuser is the operation
//   (count event, rtt sample, read statistics). Only reads produce a beat on
//   m_axis, holding the group counter, the category byte counter, the floored
//   difference of two categories and the rtt max, min and mean.
//   One command is worked on at a time; s_axis_tready is high only while the
//   sequencer is idle. All arithmetic runs through one 64-bit adder.
//   Work per command, after the accept:
//     count event: the byte counter, then a read per group slot and a write per named group
//     rtt sample:  extremes and a mean restart, else 31 shift-add multiply
//                  steps and 64 restoring divide steps in the shared adder
//     read:        both counter reads and the difference, then the output register once it is free
//   The output register lets a new command be accepted while a read result
//   waits; a read that finishes while the register is full holds there until
//   m_axis_tready drains it.
//   Reset clears the counter valid bits at once, so all counters read zero
//   with no clearing pass; rtt max, min and mean reset to -1.
module traffic_counter_bank_with_rtt_stats_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // category[2:0], ip_family[4:3], traffic_class[7:5], packet_length[39:8],
    // rtt_sample[70:40], other_category[73:71], zero pad[79:74]
    input  logic [79:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // packet_count[63:0], byte_count[127:64], count_difference[191:128],
    // rtt_max[223:192], rtt_min[255:224], rtt_mean[287:256]
    output logic [287:0] m_axis_tdata
);

    localparam int CW = tcb_pkg::COUNTER_WIDTH;
    localparam int MW = tcb_pkg::MATH_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTES,
        S_BUMP_RD,
        S_BUMP_WR,
        S_RTT_RD,
        S_RTT_EXT,
        S_MUL,
        S_ADDRTT,
        S_DIV,
        S_DIVEND,
        S_RD_A,
        S_RD_B,
        S_RD_DIFF,
        S_OUT
    } state_t;

    // input fields
    logic [2:0]  in_category;
    logic [1:0]  in_ip_family;
    logic [2:0]  in_traffic_class;
    logic [31:0] in_packet_length;
    logic [30:0] in_rtt_sample;
    logic [2:0]  in_other_category;

    assign in_category       = s_axis_tdata[2:0];
    assign in_ip_family      = s_axis_tdata[4:3];
    assign in_traffic_class  = s_axis_tdata[7:5];
    assign in_packet_length  = s_axis_tdata[39:8];
    assign in_rtt_sample     = s_axis_tdata[70:40];
    assign in_other_category = s_axis_tdata[73:71];

    state_t state_reg, state_next;

    logic [2:0]  cat_reg, cat_next;
    logic [1:0]  fam_reg, fam_next;
    logic [2:0]  cls_reg, cls_next;
    logic [31:0] len_reg, len_next;
    logic [30:0] rtt_reg, rtt_next;
    logic [2:0]  oth_reg, oth_next;
    logic [1:0]  slot_reg, slot_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [CW-1:0] byte_cnt_reg [tcb_pkg::CATEGORY_COUNT];
    logic [CW-1:0] byte_cnt_next [tcb_pkg::CATEGORY_COUNT];

    logic [31:0] max_reg, max_next;
    logic [31:0] min_reg, min_next;
    logic [31:0] avg_reg, avg_next;

    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] rem_reg, rem_next;
    logic [MW-1:0] mcand_reg, mcand_next;
    logic [30:0]   mplier_reg, mplier_next;
    logic [MW-1:0] divisor_reg, divisor_next;
    logic [MW-1:0] a_reg, a_next;
    logic [MW-1:0] diff_reg, diff_next;

    logic          m_valid_reg, m_valid_next;
    logic [MW-1:0] out_pc_reg, out_pc_next;
    logic [MW-1:0] out_bc_reg, out_bc_next;
    logic [MW-1:0] out_diff_reg, out_diff_next;
    logic [31:0]   out_max_reg, out_max_next;
    logic [31:0]   out_min_reg, out_min_next;
    logic [31:0]   out_mean_reg, out_mean_next;

    tcb_pkg::ram_req_t ram_req;
    logic [CW-1:0]     ram_rd;
    tcb_pkg::alu_req_t alu_req;
    tcb_pkg::alu_res_t alu_res;

    // working values
    logic [2:0]    slot_grp;
    logic          slot_en;
    logic [MW-1:0] rcvd;
    logic [MW-1:0] b_val;
    logic [MW:0]   rem_shift;
    logic          div_ok;

    tcb_group_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    tcb_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // group targeted by the current bump slot of a count event
    always_comb
    begin
        unique case (slot_reg)
            2'd0:
            begin
                slot_grp = tcb_pkg::GRP_TOTAL;
                slot_en  = 1'b1;
            end
            2'd1:
            begin
                slot_grp = (fam_reg == tcb_pkg::FAM_IPV4) ? tcb_pkg::GRP_IPV4
                                                          : tcb_pkg::GRP_IPV6;
                slot_en  = (fam_reg == tcb_pkg::FAM_IPV4)
                           || (fam_reg == tcb_pkg::FAM_IPV6);
            end
            default:
            begin
                slot_grp = cls_reg;
                slot_en  = (cls_reg >= tcb_pkg::GRP_ICMP4)
                           && (cls_reg <= tcb_pkg::GRP_ARP);
            end
        endcase
        slot_en = slot_en && tcb_pkg::cell_ok(slot_grp, cat_reg);
    end

    assign rcvd  = tcb_pkg::cell_ok(tcb_pkg::GRP_TOTAL, tcb_pkg::CAT_RCVD)
                   ? MW'(ram_rd) : '0;
    assign b_val = tcb_pkg::cell_ok(cls_reg, oth_reg) ? MW'(ram_rd) : '0;
    assign rem_shift = {rem_reg, acc_reg[MW-1]};
    assign div_ok    = rem_shift[MW] | alu_res.carry;

    // shared adder operand selection
    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            S_BYTES:
            begin
                alu_req.a = MW'(byte_cnt_reg[tcb_pkg::cat_index(cat_reg)]);
                alu_req.b = MW'(len_reg);
            end
            S_BUMP_WR:
            begin
                alu_req.a = MW'(ram_rd);
                alu_req.b = MW'(1);
            end
            S_RTT_EXT:
            begin
                alu_req.a = rcvd;
                alu_req.b = MW'(1);
            end
            S_MUL:
            begin
                alu_req.a = acc_reg;
                alu_req.b = mcand_reg;
            end
            S_ADDRTT:
            begin
                alu_req.a = acc_reg;
                alu_req.b = MW'(rtt_reg);
            end
            S_DIV:
            begin
                alu_req.a   = rem_shift[MW-1:0];
                alu_req.b   = divisor_reg;
                alu_req.sub = 1'b1;
            end
            S_RD_DIFF:
            begin
                alu_req.a   = a_reg;
                alu_req.b   = b_val;
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // sequencer next state and datapath updates
    always_comb
    begin
        state_next    = state_reg;
        cat_next      = cat_reg;
        fam_next      = fam_reg;
        cls_next      = cls_reg;
        len_next      = len_reg;
        rtt_next      = rtt_reg;
        oth_next      = oth_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        max_next      = max_reg;
        min_next      = min_reg;
        avg_next      = avg_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        divisor_next  = divisor_reg;
        a_next        = a_reg;
        diff_next     = diff_reg;
        m_valid_next  = m_valid_reg & ~m_axis_tready;
        out_pc_next   = out_pc_reg;
        out_bc_next   = out_bc_reg;
        out_diff_next = out_diff_reg;
        out_max_next  = out_max_reg;
        out_min_next  = out_min_reg;
        out_mean_next = out_mean_reg;
        ram_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cat_next  = in_category;
                    fam_next  = in_ip_family;
                    cls_next  = in_traffic_class;
                    len_next  = in_packet_length;
                    rtt_next  = in_rtt_sample;
                    oth_next  = in_other_category;
                    slot_next = 2'd0;
                    unique case (s_axis_tuser)
                        tcb_pkg::OP_COUNT:
                        begin
                            if (tcb_pkg::cat_ok(in_category))
                            begin
                                state_next = S_BYTES;
                            end
                        end
                        tcb_pkg::OP_RTT:  state_next = S_RTT_RD;
                        tcb_pkg::OP_READ: state_next = S_RD_A;
                        default:          state_next = S_IDLE;
                    endcase
                end
            end

            // category byte counter
            S_BYTES:
            begin
                byte_cnt_next[tcb_pkg::cat_index(cat_reg)] = alu_res.sum[CW-1:0];
                state_next = S_BUMP_RD;
            end

            // read-modify-write of each named group counter
            S_BUMP_RD:
            begin
                ram_req.raddr = tcb_pkg::cell_addr(slot_grp, cat_reg);
                if (slot_en)
                begin
                    state_next = S_BUMP_WR;
                end
                else if (slot_reg == 2'd2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + 2'd1;
                end
            end

            S_BUMP_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = tcb_pkg::cell_addr(slot_grp, cat_reg);
                ram_req.wdata = alu_res.sum[CW-1:0];
                if (slot_reg == 2'd2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + 2'd1;
                    state_next = S_BUMP_RD;
                end
            end

            // fetch the received counter for the mean
            S_RTT_RD:
            begin
                ram_req.raddr = tcb_pkg::cell_addr(tcb_pkg::GRP_TOTAL, tcb_pkg::CAT_RCVD);
                state_next    = S_RTT_EXT;
            end

            // extremes, and mean restart or multiply setup
            S_RTT_EXT:
            begin
                if (max_reg[31] || ({1'b0, rtt_reg} > max_reg))
                begin
                    max_next = {1'b0, rtt_reg};
                end
                if (min_reg[31] || ({1'b0, rtt_reg} < min_reg))
                begin
                    min_next = {1'b0, rtt_reg};
                end
                if ((rcvd == '0) || avg_reg[31] || alu_res.carry)
                begin
                    avg_next   = {1'b0, rtt_reg};
                    state_next = S_IDLE;
                end
                else
                begin
                    mcand_next   = rcvd;
                    mplier_next  = avg_reg[30:0];
                    acc_next     = '0;
                    cnt_next     = '0;
                    divisor_next = alu_res.sum;
                    state_next   = S_MUL;
                end
            end

            // shift-add multiply of mean by received count
            S_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = alu_res.sum;
                end
                mcand_next  = {mcand_reg[MW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[30:1]};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'(tcb_pkg::MUL_STEPS - 1))
                begin
                    state_next = S_ADDRTT;
                end
            end

            S_ADDRTT:
            begin
                acc_next   = alu_res.sum;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            // restoring divide, one quotient bit per cycle
            S_DIV:
            begin
                rem_next = div_ok ? alu_res.sum : rem_shift[MW-1:0];
                acc_next = {acc_reg[MW-2:0], div_ok};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MW - 1))
                begin
                    state_next = S_DIVEND;
                end
            end

            // saturate the quotient into the mean
            S_DIVEND:
            begin
                avg_next   = (acc_reg[MW-1:31] != '0) ? tcb_pkg::RTT_SAT : acc_reg[31:0];
                state_next = S_IDLE;
            end

            // statistics read
            S_RD_A:
            begin
                ram_req.raddr = tcb_pkg::cell_addr(cls_reg, cat_reg);
                state_next    = S_RD_B;
            end

            S_RD_B:
            begin
                a_next        = tcb_pkg::cell_ok(cls_reg, cat_reg) ? MW'(ram_rd) : '0;
                ram_req.raddr = tcb_pkg::cell_addr(cls_reg, oth_reg);
                state_next    = S_RD_DIFF;
            end

            S_RD_DIFF:
            begin
                diff_next  = alu_res.carry ? alu_res.sum : '0;
                state_next = S_OUT;
            end

            // load the output register once it is free
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_pc_next   = a_reg;
                    out_bc_next   = tcb_pkg::cat_ok(cat_reg)
                                    ? MW'(byte_cnt_reg[tcb_pkg::cat_index(cat_reg)]) : '0;
                    out_diff_next = diff_reg;
                    out_max_next  = max_reg;
                    out_min_next  = min_reg;
                    out_mean_next = avg_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, counters and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            max_reg     <= tcb_pkg::RTT_NONE;
            min_reg     <= tcb_pkg::RTT_NONE;
            avg_reg     <= tcb_pkg::RTT_NONE;
            for (int i = 0; i < tcb_pkg::CATEGORY_COUNT; i++)
            begin
                byte_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            max_reg      <= max_next;
            min_reg      <= min_next;
            avg_reg      <= avg_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cat_reg      <= cat_next;
        fam_reg      <= fam_next;
        cls_reg      <= cls_next;
        len_reg      <= len_next;
        rtt_reg      <= rtt_next;
        oth_reg      <= oth_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        divisor_reg  <= divisor_next;
        a_reg        <= a_next;
        diff_reg     <= diff_next;
        out_pc_reg   <= out_pc_next;
        out_bc_reg   <= out_bc_next;
        out_diff_reg <= out_diff_next;
        out_max_reg  <= out_max_next;
        out_min_reg  <= out_min_next;
        out_mean_reg <= out_mean_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_mean_reg, out_min_reg, out_max_reg,
                            out_diff_reg, out_bc_reg, out_pc_reg};

endmodule

@@ sim/tb_top.sv @@
// testbench of traffic_counter_bank_with_rtt_stats_core: commands go in on s_axis, read
// results are predicted from a bit-exact model of the counters and rtt figures and compared
// depends on tcb_pkg and the core top level
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] FAM_NONE  = 2'd0;
    localparam logic [1:0] FAM_BAD   = 2'd3;

    // one command beat, fields as in s_axis
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  category;
        logic [1:0]  family;
        logic [2:0]  tclass;
        logic [31:0] length;
        logic [30:0] rtt;
        logic [2:0]  other_cat;
    } cmd_t;

    // one read result beat
    typedef struct packed {
        logic [63:0] packet_count;
        logic [63:0] byte_count;
        logic [63:0] count_difference;
        logic [31:0] rtt_max;
        logic [31:0] rtt_min;
        logic [31:0] rtt_mean;
    } stats_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [287:0] m_axis_tdata;

    // model of the counter bank
    logic [tcb_pkg::COUNTER_WIDTH-1:0] group_cnt [tcb_pkg::GROUP_COUNT][tcb_pkg::CATEGORY_COUNT];
    logic [tcb_pkg::COUNTER_WIDTH-1:0] cat_bytes [tcb_pkg::CATEGORY_COUNT];
    logic [31:0] rtt_hi, rtt_lo, rtt_avg;

    stats_t pending_stats[$];
    int     fail_count = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;

    traffic_counter_bank_with_rtt_stats_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // state right after reset
    task automatic clear_counter_model();
        for (int g = 0; g < tcb_pkg::GROUP_COUNT; g++)
            for (int c = 0; c < tcb_pkg::CATEGORY_COUNT; c++)
                group_cnt[g][c] = '0;
        for (int c = 0; c < tcb_pkg::CATEGORY_COUNT; c++)
            cat_bytes[c] = '0;
        rtt_hi  = tcb_pkg::RTT_NONE;
        rtt_lo  = tcb_pkg::RTT_NONE;
        rtt_avg = tcb_pkg::RTT_NONE;
    endtask

    function automatic logic [63:0] group_value(logic [2:0] grp, logic [2:0] cat);
        if (int'(grp) >= tcb_pkg::GROUP_COUNT || int'(cat) >= tcb_pkg::CATEGORY_COUNT)
            return 64'd0;
        return 64'(group_cnt[grp][cat]);
    endfunction

    task automatic bump_group(logic [2:0] grp, logic [2:0] cat);
        if (int'(grp) < tcb_pkg::GROUP_COUNT && int'(cat) < tcb_pkg::CATEGORY_COUNT)
            group_cnt[grp][cat] = group_cnt[grp][cat] + 1'b1;
    endtask

    // update the model with one accepted command, queue a result for reads
    task automatic apply_command(cmd_t c);
        logic [63:0] rcvd, quo, a, b;
        stats_t      r;
        unique case (c.op)
            tcb_pkg::OP_COUNT:
            begin
                if (int'(c.category) < tcb_pkg::CATEGORY_COUNT)
                begin
                    bump_group(tcb_pkg::GRP_TOTAL, c.category);
                    cat_bytes[c.category] = cat_bytes[c.category] + c.length;
                    if (c.family == tcb_pkg::FAM_IPV4)
                        bump_group(tcb_pkg::GRP_IPV4, c.category);
                    else if (c.family == tcb_pkg::FAM_IPV6)
                        bump_group(tcb_pkg::GRP_IPV6, c.category);
                    if (c.tclass >= tcb_pkg::GRP_ICMP4 && c.tclass <= tcb_pkg::GRP_ARP)
                        bump_group(c.tclass, c.category);
                end
            end
            tcb_pkg::OP_RTT:
            begin
                rcvd = group_value(tcb_pkg::GRP_TOTAL, tcb_pkg::CAT_RCVD);
                if (rtt_hi[31] || {1'b0, c.rtt} > rtt_hi)
                    rtt_hi = {1'b0, c.rtt};
                if (rtt_lo[31] || {1'b0, c.rtt} < rtt_lo)
                    rtt_lo = {1'b0, c.rtt};
                // mean restarts when nothing was received yet, no mean is held yet, or the divisor wraps
                if (rcvd == 64'd0 || rtt_avg[31] || rcvd + 64'd1 == 64'd0)
                    rtt_avg = {1'b0, c.rtt};
                else
                begin
                    quo = (64'(rtt_avg) * rcvd + 64'(c.rtt)) / (rcvd + 64'd1);
                    rtt_avg = (quo > 64'(tcb_pkg::RTT_SAT)) ? tcb_pkg::RTT_SAT : quo[31:0];
                end
            end
            tcb_pkg::OP_READ:
            begin
                a = group_value(c.tclass, c.category);
                b = group_value(c.tclass, c.other_cat);
                r.packet_count     = a;
                r.byte_count       = (int'(c.category) < tcb_pkg::CATEGORY_COUNT) ?
                                     64'(cat_bytes[c.category]) : 64'd0;
                r.count_difference = (a > b) ? a - b : 64'd0;
                r.rtt_max          = rtt_hi;
                r.rtt_min          = rtt_lo;
                r.rtt_mean         = rtt_avg;
                pending_stats.push_back(r);
            end
            default: ;
        endcase
    endtask

    // drive one command beat, with random idle cycles in front
    task automatic send_command(cmd_t c);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {6'd0, c.other_cat, c.rtt, c.length, c.tclass, c.family,
                          c.category};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_command(c);
    endtask

    function automatic cmd_t make_cmd(logic [1:0] op, logic [2:0] cat, logic [1:0] fam,
                                      logic [2:0] cls, logic [31:0] len, logic [30:0] rtt,
                                      logic [2:0] oth);
        cmd_t c;
        c.op        = op;
        c.category  = cat;
        c.family    = fam;
        c.tclass    = cls;
        c.length    = len;
        c.rtt       = rtt;
        c.other_cat = oth;
        return c;
    endfunction

    // stop sending until every read result is back, then let a slow rtt update finish
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // reset values, unused operation and mean restart with nothing received
    task automatic test_reset_values();
        send_command(make_cmd(tcb_pkg::OP_READ, tcb_pkg::CAT_RCVD, FAM_NONE,
                              tcb_pkg::GRP_TOTAL, 32'd0, 31'd0, 3'd0));
        send_command(make_cmd(OP_UNUSED, 3'd7, FAM_BAD, 3'd7, 32'hFFFF_FFFF,
                              31'h7FFF_FFFF, 3'd7));
        send_command(make_cmd(tcb_pkg::OP_RTT, 3'd0, FAM_NONE, 3'd0, 32'd0, 31'd5, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_RTT, 3'd7, FAM_BAD, 3'd7, 32'hFFFF_FFFF,
                              31'h7FFF_FFFF, 3'd7));
        send_command(make_cmd(tcb_pkg::OP_READ, 3'd7, FAM_BAD, 3'd7, 32'hFFFF_FFFF, 31'd0,
                              3'd7));
    endtask

    // count events over families and classes, then a read of every group
    task automatic test_count_events();
        send_command(make_cmd(tcb_pkg::OP_COUNT, tcb_pkg::CAT_RCVD, tcb_pkg::FAM_IPV4, 3'd3,
                              32'hFFFF_FFFF, 31'd0, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_COUNT, tcb_pkg::CAT_RCVD, tcb_pkg::FAM_IPV6,
                              tcb_pkg::GRP_ARP, 32'd0, 31'd0, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_COUNT, tcb_pkg::CAT_RCVD, FAM_BAD,
                              tcb_pkg::GRP_IPV6, 32'd1, 31'd0, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_COUNT, 3'd0, FAM_NONE, tcb_pkg::GRP_IPV4,
                              32'd12345, 31'd0, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_COUNT, 3'd7, tcb_pkg::FAM_IPV4, tcb_pkg::GRP_ICMP4,
                              32'h8000_0000, 31'd0, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_COUNT, 3'd2, tcb_pkg::FAM_IPV6, 3'd2,
                              32'h7FFF_FFFF, 31'd0, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_COUNT, tcb_pkg::CAT_RCVD, FAM_NONE, 3'd4, 32'd64,
                              31'd0, 3'd0));
        for (int g = 0; g < 8; g++)
            send_command(make_cmd(tcb_pkg::OP_READ, tcb_pkg::CAT_RCVD, FAM_NONE, 3'(g),
                                  32'd0, 31'd0, g[0] ? 3'd0 : 3'd7));
    endtask

    // running mean with packets received
    task automatic test_rtt_mean();
        send_command(make_cmd(tcb_pkg::OP_RTT, 3'd0, FAM_NONE, 3'd0, 32'd0, 31'd0, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_RTT, 3'd0, FAM_NONE, 3'd0, 32'd0, 31'd1000, 3'd0));
        send_command(make_cmd(tcb_pkg::OP_READ, tcb_pkg::CAT_RCVD, FAM_NONE,
                              tcb_pkg::GRP_TOTAL, 32'd0, 31'd0, 3'd2));
    endtask

    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        c.category  = 3'($urandom_range(0, 7));
        c.family    = 2'($urandom_range(0, 3));
        c.tclass    = 3'($urandom_range(0, 7));
        c.length    = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 1500)) : $urandom;
        c.rtt       = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 5000));
        c.other_cat = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c.op = tcb_pkg::OP_COUNT;
        else if (pick < 65)
            c.op = tcb_pkg::OP_RTT;
        else if (pick < 95)
            c.op = tcb_pkg::OP_READ;
        else
            c.op = OP_UNUSED;
        return c;
    endfunction

    // random traffic under one idling pattern, with a full drain halfway
    task automatic test_random_traffic(int n, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain_pause();
            send_command(random_command());
        end
        drain_pause();
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // compare each read result beat with the oldest prediction
    always @(posedge clk)
    begin
        stats_t got;
        stats_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.packet_count     = m_axis_tdata[63:0];
            got.byte_count       = m_axis_tdata[127:64];
            got.count_difference = m_axis_tdata[191:128];
            got.rtt_max          = m_axis_tdata[223:192];
            got.rtt_min          = m_axis_tdata[255:224];
            got.rtt_mean         = m_axis_tdata[287:256];
            if (pending_stats.size() == 0)
            begin
                $error("result beat with no read outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                check_field("packet_count", want.packet_count, got.packet_count);
                check_field("byte_count", want.byte_count, got.byte_count);
                check_field("count_difference", want.count_difference,
                            got.count_difference);
                check_field("rtt_max", 64'(want.rtt_max), 64'(got.rtt_max));
                check_field("rtt_min", 64'(want.rtt_min), 64'(got.rtt_min));
                check_field("rtt_mean", 64'(want.rtt_mean), 64'(got.rtt_mean));
            end
        end
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("** traffic_counter_bank_with_rtt_stats_core: FAILED **");
        $finish;
    end

    initial
    begin
        clear_counter_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 29;
        rx_idle_pct = 48;
        test_reset_values();
        test_count_events();
        test_rtt_mean();
        drain_pause();
        test_random_traffic(480, 29, 48);
        test_random_traffic(480, 48, 29);
        test_random_traffic(470, 0, 0);
        if (fail_count == 0)
            $display("** traffic_counter_bank_with_rtt_stats_core: PASSED **");
        else
            $display("** traffic_counter_bank_with_rtt_stats_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tcb_pkg.sv
src/tcb_alu.sv
src/tcb_group_ram.sv
src/traffic_counter_bank_with_rtt_stats_core.sv
sim/tb_top.sv
